@@ hw/rtl/read_command_sequencer_defines.svh @@
// Assertion macros shared by the read command sequencer RTL.
// Depends on nothing; included by the files that carry concurrent assertions.
`ifndef READ_COMMAND_SEQUENCER_DEFINES_SVH
`define READ_COMMAND_SEQUENCER_DEFINES_SVH
`ifndef SYNTHESIS
// Property checked at every rising clock edge outside reset.
`define RCS_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Property checked at every rising clock edge, reset included.
`define RCS_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RCS_ASSERT(label, clk, rst_n, prop, msg)
`define RCS_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

@@ hw/rtl/rcs_pkg.sv @@
// Shared types and constants of the read command sequencer.
// No dependencies; imported by every module of the block.
package rcs_pkg;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W = 8;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_WAIT_CYCLES = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_READ_OPCODE = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_IDLE_OPCODE = 2'd2;

	// Input item kinds and result kinds.
	localparam logic KIND_START = 1'b0;
	localparam logic KIND_RESPONSE = 1'b1;
	localparam logic RES_TRANSFER = 1'b0;
	localparam logic RES_FINISHED = 1'b1;

	// Finished status codes.
	localparam logic [1:0] STAT_OK = 2'd0;
	localparam logic [1:0] STAT_INVALID = 2'd1;
	localparam logic [1:0] STAT_PROTOCOL = 2'd2;

	// Progress codes the chip returns on the data output.
	localparam logic [7:0] PROG_CMD = 8'h00;
	localparam logic [7:0] PROG_ADAPT = 8'h30;
	localparam logic [7:0] PROG_ROW = 8'h31;
	localparam logic [7:0] PROG_MODE = 8'h32;
	localparam logic [7:0] PROG_UNIT = 8'h33;
	localparam logic [7:0] PROG_CELL = 8'h34;
	localparam logic [7:0] PROG_START = 8'h35;
	localparam logic [7:0] PROG_WAIT = 8'h36;

	// Bits that must be clear in a result-bit response.
	localparam logic [7:0] RESULT_BIT_MASK = 8'hFE;
	// Highest legal unit in single mode.
	localparam logic [6:0] UNIT_MAX = 7'd64;

	typedef struct packed {
		logic [2:0] wait_cycles;
		logic [7:0] read_opcode;
		logic [7:0] idle_opcode;
	} cfg_t;

	typedef struct packed {
		logic       kind;
		logic       adaptive_wordline;
		logic [6:0] row_address;
		logic       single_unit;
		logic [6:0] unit_select;
		logic [1:0] cell_select;
		logic       response_valid;
		logic [7:0] response_data;
	} item_t;

	typedef struct packed {
		logic        result_kind;
		logic        command_bit;
		logic [7:0]  data_byte;
		logic [1:0]  status;
		logic [63:0] row_bits;
		logic        unit_zero_bit;
		logic        last;
	} result_t;

	// What one processed item hands to the output stage.
	typedef struct packed {
		logic    has_result;
		logic    abort;
		result_t res;
	} step_out_t;

endpackage

@@ hw/rtl/rcs_cfg.sv @@
// Configuration registers of the read command sequencer.
// Depends on rcs_pkg for register indexes and the cfg_t bundle.
module rcs_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [rcs_pkg::CFG_INDEX_W-1:0] wr_index,
	input  logic [rcs_pkg::CFG_DATA_W-1:0]  wr_data,
	output rcs_pkg::cfg_t                 cfg
);
	import rcs_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_WAIT_CYCLES: cfg_q.wait_cycles <= wr_data[2:0];
				REG_READ_OPCODE: cfg_q.read_opcode <= wr_data;
				REG_IDLE_OPCODE: cfg_q.idle_opcode <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ hw/rtl/rcs_step.sv @@
// Read sequencer state and the single-pass step logic for one item.
// Depends on rcs_pkg and on the assertion macros header.
`include "read_command_sequencer_defines.svh"
module rcs_step (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  rcs_pkg::item_t      item,
	input  rcs_pkg::cfg_t       cfg,
	output rcs_pkg::step_out_t  step
);
	import rcs_pkg::*;

	typedef enum logic [3:0] {
		PH_IDLE, PH_CMD, PH_ADAPT, PH_ROW, PH_MODE, PH_UNIT, PH_CELL,
		PH_START, PH_WAIT, PH_SINGLE, PH_GROUP, PH_UNIT0
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [2:0]  waits_q, waits_d;
	logic [2:0]  group_q, group_d;
	logic [63:0] coll_q, coll_d;
	logic        held_adapt_q;
	logic [6:0]  held_row_q;
	logic        held_mode_q;
	logic [6:0]  held_unit_q;
	logic [1:0]  held_cell_q;
	logic        load_held;
	logic        do_abort;
	logic        prog_ok;
	logic        bit_ok;
	logic [7:0]  expect_code;
	phase_t      data_phase;

	// Progress code expected in answer to the transfer driven from each phase.
	always_comb begin
		case (phase_q)
			PH_CMD:   expect_code = PROG_CMD;
			PH_ADAPT: expect_code = PROG_ADAPT;
			PH_ROW:   expect_code = PROG_ROW;
			PH_MODE:  expect_code = PROG_MODE;
			PH_UNIT:  expect_code = PROG_UNIT;
			PH_CELL:  expect_code = PROG_CELL;
			PH_START: expect_code = PROG_START;
			default:  expect_code = PROG_WAIT;
		endcase
	end

	assign prog_ok = !item.response_valid && (item.response_data == expect_code);
	assign bit_ok = item.response_valid && ((item.response_data & RESULT_BIT_MASK) == 8'h00);
	assign data_phase = held_mode_q ? PH_SINGLE : PH_GROUP;

	always_comb begin
		phase_d = phase_q;
		waits_d = waits_q;
		group_d = group_q;
		coll_d = coll_q;
		load_held = 1'b0;
		do_abort = 1'b0;
		step = '0;
		// Most responses answer with a plain data transfer that ends the item.
		step.res.result_kind = RES_TRANSFER;
		step.res.last = 1'b1;
		if (item.kind == KIND_START) begin
			phase_d = PH_IDLE;
			waits_d = '0;
			group_d = '0;
			coll_d = '0;
			step.has_result = 1'b1;
			if (item.single_unit && (item.unit_select > UNIT_MAX)) begin
				step.res.result_kind = RES_FINISHED;
				step.res.status = STAT_INVALID;
			end else begin
				load_held = 1'b1;
				phase_d = PH_CMD;
				step.res.command_bit = 1'b1;
				step.res.data_byte = cfg.read_opcode;
			end
		end else begin
			unique case (phase_q)
				PH_IDLE: ;
				PH_CMD: begin
					do_abort = !prog_ok;
					phase_d = PH_ADAPT;
					step.res.data_byte = {7'd0, held_adapt_q};
				end
				PH_ADAPT: begin
					do_abort = !prog_ok;
					phase_d = PH_ROW;
					step.res.data_byte = {1'b0, held_row_q};
				end
				PH_ROW: begin
					do_abort = !prog_ok;
					phase_d = PH_MODE;
					step.res.data_byte = {7'd0, held_mode_q};
				end
				PH_MODE: begin
					do_abort = !prog_ok;
					phase_d = PH_UNIT;
					step.res.data_byte = {1'b0, held_unit_q};
				end
				PH_UNIT: begin
					do_abort = !prog_ok;
					phase_d = PH_CELL;
					step.res.data_byte = {6'd0, held_cell_q};
				end
				PH_CELL: begin
					do_abort = !prog_ok;
					phase_d = PH_START;
				end
				PH_START: begin
					do_abort = !prog_ok;
					waits_d = cfg.wait_cycles;
					group_d = '0;
					coll_d = '0;
					phase_d = (cfg.wait_cycles != 3'd0) ? PH_WAIT : data_phase;
				end
				PH_WAIT: begin
					do_abort = !prog_ok;
					waits_d = waits_q - 3'd1;
					if (waits_q == 3'd1) begin
						phase_d = data_phase;
					end
				end
				PH_GROUP: begin
					do_abort = !item.response_valid;
					coll_d[{group_q, 3'b000} +: 8] = item.response_data;
					group_d = group_q + 3'd1;
					if (group_q == 3'd7) begin
						phase_d = PH_UNIT0;
					end
				end
				PH_SINGLE, PH_UNIT0: begin
					do_abort = !bit_ok;
					phase_d = PH_IDLE;
					step.res.result_kind = RES_FINISHED;
					step.res.status = STAT_OK;
					step.res.unit_zero_bit = item.response_data[0];
					step.res.row_bits = (phase_q == PH_UNIT0) ? coll_q : 64'd0;
				end
				default: ;
			endcase
			step.has_result = (phase_q != PH_IDLE);
			// A mismatch answers with an idle command; the error result follows.
			if (do_abort) begin
				phase_d = PH_IDLE;
				waits_d = '0;
				group_d = '0;
				coll_d = '0;
				step.abort = 1'b1;
				step.res = '0;
				step.res.result_kind = RES_TRANSFER;
				step.res.command_bit = 1'b1;
				step.res.data_byte = cfg.idle_opcode;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			waits_q <= '0;
			group_q <= '0;
			coll_q <= '0;
			held_adapt_q <= 1'b0;
			held_row_q <= '0;
			held_mode_q <= 1'b0;
			held_unit_q <= '0;
			held_cell_q <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			waits_q <= waits_d;
			group_q <= group_d;
			coll_q <= coll_d;
			if (load_held) begin
				held_adapt_q <= item.adaptive_wordline;
				held_row_q <= item.row_address;
				held_mode_q <= item.single_unit;
				held_unit_q <= item.single_unit ? item.unit_select : 7'd0;
				held_cell_q <= item.cell_select;
			end
		end
	end

	`RCS_ASSERT(a_abort_to_idle, clk, arst_n, (fire && step.abort) |=> (phase_q == PH_IDLE), "abort did not return the sequencer to idle")
	`RCS_ASSERT(a_wait_nonzero, clk, arst_n, (phase_q == PH_WAIT) |-> (waits_q != 3'd0), "wait phase entered with no wait cycles left")

endmodule

@@ hw/rtl/rcs_out.sv @@
// Result register and the pending protocol-error result of an abort.
// Depends on rcs_pkg and on the assertion macros header.
`include "read_command_sequencer_defines.svh"
module rcs_out (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  rcs_pkg::step_out_t  step,
	output logic                can_load,
	output logic                out_valid,
	input  logic                out_stall,
	output rcs_pkg::result_t    out_res
);
	import rcs_pkg::*;

	result_t out_q;
	logic    out_valid_q;
	logic    pend_q;
	logic    drain;
	logic    free;
	result_t err_res;

	always_comb begin
		err_res = '0;
		err_res.result_kind = RES_FINISHED;
		err_res.status = STAT_PROTOCOL;
		err_res.last = 1'b1;
	end

	assign drain = out_valid_q && !out_stall;
	assign free = !out_valid_q || drain;
	assign can_load = free && !pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_q <= 1'b0;
		end else if (pend_q && free) begin
			out_valid_q <= 1'b1;
			pend_q <= 1'b0;
		end else if (fire && step.has_result) begin
			out_valid_q <= 1'b1;
			pend_q <= step.abort;
		end else if (drain) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_q && free) begin
			out_q <= err_res;
		end else if (fire && step.has_result) begin
			out_q <= step.res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res = out_q;

	`RCS_ASSERT_ALWAYS(a_pend_behind_result, clk, !pend_q || out_valid_q, "error result pending with no result held")
	`RCS_ASSERT(a_error_follows_abort, clk, arst_n, (out_valid_q && !out_stall && !out_q.last) |=> (out_valid_q && out_q.result_kind == RES_FINISHED && out_q.status == STAT_PROTOCOL), "idle command not followed by the protocol error result")

endmodule

@@ hw/rtl/read_command_sequencer.sv @@
// Top level of the read command sequencer: item register, sequencer step,
// result stage and configuration registers. Depends on rcs_pkg, rcs_cfg,
// rcs_step and rcs_out.
//
// The block drives the host side of a memory chip READ command. A start item
// (kind 0) carries the read fields; each chip response (kind 1) carries the
// valid flag and data byte sampled after the previous transfer. Every item
// yields at most two results: a transfer cycle to drive on the chip bus, a
// finished result with status and collected unit bits, or, on a protocol
// mismatch, an idle command followed by a protocol-error result.
// Items enter on item_valid/item_stall; a transfer takes place at an edge
// with valid high and stall low. Results leave on result_valid/result_stall
// in the same way, with last marking the final result of an item.
// Configuration is written through cfg_valid/cfg_ready, which is always
// ready; write it only while no read is under way.
// The first result of an item passes through the item register and then the
// result register before it is offered. Throughput is one item per cycle
// while result_stall stays low; an abort occupies the result register with
// two results in turn, the idle command and then the error result, so the
// item channel stalls behind it until the error result has been loaded.
// While the receiver stalls, the held result stays stable and one more item
// is buffered in the item register before item_stall rises.
// Reset clears the configuration to zero, puts the sequencer in idle and
// empties both registers.
module read_command_sequencer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic                          kind,
	input  logic                          adaptive_wordline,
	input  logic [6:0]                    row_address,
	input  logic                          single_unit,
	input  logic [6:0]                    unit_select,
	input  logic [1:0]                    cell_select,
	input  logic                          response_valid,
	input  logic [7:0]                    response_data,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic                          result_kind,
	output logic                          command_bit,
	output logic [7:0]                    data_byte,
	output logic [1:0]                    status,
	output logic [63:0]                   row_bits,
	output logic                          unit_zero_bit,
	output logic                          last,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rcs_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [rcs_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import rcs_pkg::*;

	item_t     item_s1;
	logic      item_valid_s1;
	logic      item_take;
	logic      fire;
	logic      can_load;
	cfg_t      cfg;
	step_out_t step;
	result_t   out_res;

	// The item register hands its item on as soon as the result stage can
	// accept all of that item's results.
	assign fire = item_valid_s1 && can_load;
	assign item_stall = item_valid_s1 && !fire;
	assign item_take = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (item_take) begin
			item_valid_s1 <= 1'b1;
		end else if (fire) begin
			item_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_take) begin
			item_s1.kind <= kind;
			item_s1.adaptive_wordline <= adaptive_wordline;
			item_s1.row_address <= row_address;
			item_s1.single_unit <= single_unit;
			item_s1.unit_select <= unit_select;
			item_s1.cell_select <= cell_select;
			item_s1.response_valid <= response_valid;
			item_s1.response_data <= response_data;
		end
	end

	assign cfg_ready = 1'b1;

	rcs_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	rcs_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg),
		.step   (step)
	);

	rcs_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.step      (step),
		.can_load  (can_load),
		.out_valid (result_valid),
		.out_stall (result_stall),
		.out_res   (out_res)
	);

	assign result_kind = out_res.result_kind;
	assign command_bit = out_res.command_bit;
	assign data_byte = out_res.data_byte;
	assign status = out_res.status;
	assign row_bits = out_res.row_bits;
	assign unit_zero_bit = out_res.unit_zero_bit;
	assign last = out_res.last;

endmodule

@@ tb/read_sequence_checker.sv @@
// Checker for the read command sequencer: watches the item, result and register
// write channels, tracks the sequencer state and compares every result transfer.
// Depends on rcs_pkg for the item and result layouts and the protocol codes.
module read_sequence_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	input  logic                            item_stall,
	input  logic                            kind,
	input  logic                            adaptive_wordline,
	input  logic [6:0]                      row_address,
	input  logic                            single_unit,
	input  logic [6:0]                      unit_select,
	input  logic [1:0]                      cell_select,
	input  logic                            response_valid,
	input  logic [7:0]                      response_data,
	input  logic                            result_valid,
	input  logic                            result_stall,
	input  logic                            result_kind,
	input  logic                            command_bit,
	input  logic [7:0]                      data_byte,
	input  logic [1:0]                      status,
	input  logic [63:0]                     row_bits,
	input  logic                            unit_zero_bit,
	input  logic                            last,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [rcs_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [rcs_pkg::CFG_DATA_W-1:0]  cfg_data,
	output int                              fail_count,
	output int                              outstanding,
	output int                              results_taken,
	output int                              reads_done,
	output int                              rejects,
	output int                              aborts
);
	import rcs_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_CMD, S_ADAPT, S_ROW, S_MODE, S_UNIT, S_CELL,
		S_START, S_WAIT, S_SINGLE, S_GROUP, S_UNIT0
	} seq_phase_t;

	logic [2:0]  wait_setting = '0;
	logic [7:0]  read_op = '0;
	logic [7:0]  idle_op = '0;

	seq_phase_t  phase = S_IDLE;
	logic [2:0]  waits_left = '0;
	logic [3:0]  group_index = '0;
	logic [63:0] gathered_bits = '0;
	logic        held_adaptive = 1'b0;
	logic [6:0]  held_row = '0;
	logic        held_mode = 1'b0;
	logic [6:0]  held_unit = '0;
	logic [1:0]  held_cell = '0;

	result_t     upcoming_results[$];
	item_t       seen_item;
	result_t     seen_result;

	initial begin
		fail_count = 0;
		outstanding = 0;
		results_taken = 0;
		reads_done = 0;
		rejects = 0;
		aborts = 0;
	end

	task automatic queue_result(input logic res_kind, input logic cmd, input logic [7:0] data,
			input logic [1:0] stat, input logic [63:0] bits, input logic zero,
			input logic fin);
		result_t r;
		r.result_kind = res_kind;
		r.command_bit = cmd;
		r.data_byte = data;
		r.status = stat;
		r.row_bits = bits;
		r.unit_zero_bit = zero;
		r.last = fin;
		upcoming_results.push_back(r);
	endtask

	task automatic next_transfer(input logic [7:0] data);
		queue_result(RES_TRANSFER, 1'b0, data, STAT_OK, '0, 1'b0, 1'b1);
	endtask

	task automatic finish_read(input logic [1:0] stat, input logic [63:0] bits,
			input logic zero);
		queue_result(RES_FINISHED, 1'b0, 8'h00, stat, bits, zero, 1'b1);
	endtask

	// An idle command goes out first, then the protocol error closes the read.
	task automatic abort_read();
		queue_result(RES_TRANSFER, 1'b1, idle_op, STAT_OK, '0, 1'b0, 1'b0);
		finish_read(STAT_PROTOCOL, '0, 1'b0);
		phase = S_IDLE;
		waits_left = '0;
		group_index = '0;
		gathered_bits = '0;
	endtask

	function automatic logic progress_seen(input item_t it, input logic [7:0] code);
		return !it.response_valid && it.response_data == code;
	endfunction

	function automatic logic result_bit_seen(input item_t it);
		return it.response_valid && (it.response_data & RESULT_BIT_MASK) == 8'h00;
	endfunction

	function automatic seq_phase_t after_waits();
		return held_mode ? S_SINGLE : S_GROUP;
	endfunction

	task automatic step_read_sequence(input item_t it);
		if (it.kind == KIND_START) begin
			phase = S_IDLE;
			waits_left = '0;
			group_index = '0;
			gathered_bits = '0;
			if (it.single_unit && it.unit_select > UNIT_MAX) begin
				finish_read(STAT_INVALID, '0, 1'b0);
			end else begin
				held_adaptive = it.adaptive_wordline;
				held_row = it.row_address;
				held_mode = it.single_unit;
				held_unit = it.single_unit ? it.unit_select : 7'd0;
				held_cell = it.cell_select;
				phase = S_CMD;
				queue_result(RES_TRANSFER, 1'b1, read_op, STAT_OK, '0, 1'b0, 1'b1);
			end
		end else begin
			case (phase)
				S_CMD: if (!progress_seen(it, PROG_CMD)) abort_read();
				else begin
					phase = S_ADAPT;
					next_transfer({7'd0, held_adaptive});
				end
				S_ADAPT: if (!progress_seen(it, PROG_ADAPT)) abort_read();
				else begin
					phase = S_ROW;
					next_transfer({1'b0, held_row});
				end
				S_ROW: if (!progress_seen(it, PROG_ROW)) abort_read();
				else begin
					phase = S_MODE;
					next_transfer({7'd0, held_mode});
				end
				S_MODE: if (!progress_seen(it, PROG_MODE)) abort_read();
				else begin
					phase = S_UNIT;
					next_transfer({1'b0, held_unit});
				end
				S_UNIT: if (!progress_seen(it, PROG_UNIT)) abort_read();
				else begin
					phase = S_CELL;
					next_transfer({6'd0, held_cell});
				end
				S_CELL: if (!progress_seen(it, PROG_CELL)) abort_read();
				else begin
					phase = S_START;
					next_transfer(8'h00);
				end
				S_START: if (!progress_seen(it, PROG_START)) abort_read();
				else begin
					// The wait count is taken from the register at this point.
					waits_left = wait_setting;
					group_index = '0;
					gathered_bits = '0;
					phase = (waits_left != 3'd0) ? S_WAIT : after_waits();
					next_transfer(8'h00);
				end
				S_WAIT: if (!progress_seen(it, PROG_WAIT)) abort_read();
				else begin
					waits_left = waits_left - 3'd1;
					if (waits_left == 3'd0) phase = after_waits();
					next_transfer(8'h00);
				end
				S_SINGLE: if (!result_bit_seen(it)) abort_read();
				else begin
					phase = S_IDLE;
					finish_read(STAT_OK, '0, it.response_data[0]);
				end
				S_GROUP: if (!it.response_valid) abort_read();
				else begin
					gathered_bits = gathered_bits
						| ({56'd0, it.response_data} << (8 * group_index[2:0]));
					group_index = group_index + 4'd1;
					if (group_index >= 4'd8) phase = S_UNIT0;
					next_transfer(8'h00);
				end
				S_UNIT0: if (!result_bit_seen(it)) abort_read();
				else begin
					phase = S_IDLE;
					finish_read(STAT_OK, gathered_bits, it.response_data[0]);
				end
				default: ;
			endcase
		end
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			fail_count++;
			$error("%s: expected %h, got %h", name, want, got);
		end
	endtask

	task automatic compare_result(input result_t got);
		result_t want;
		results_taken++;
		if (upcoming_results.size() == 0) begin
			fail_count++;
			$error("result transfer with nothing outstanding: kind %0d data %h status %0d",
				got.result_kind, got.data_byte, got.status);
		end else begin
			want = upcoming_results.pop_front();
			check_field("result_kind", 64'(want.result_kind), 64'(got.result_kind));
			check_field("command_bit", 64'(want.command_bit), 64'(got.command_bit));
			check_field("data_byte", 64'(want.data_byte), 64'(got.data_byte));
			check_field("status", 64'(want.status), 64'(got.status));
			check_field("row_bits", want.row_bits, got.row_bits);
			check_field("unit_zero_bit", 64'(want.unit_zero_bit), 64'(got.unit_zero_bit));
			check_field("last", 64'(want.last), 64'(got.last));
			if (want.result_kind == RES_FINISHED) begin
				case (want.status)
					STAT_OK: reads_done++;
					STAT_INVALID: rejects++;
					default: aborts++;
				endcase
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_setting = '0;
			read_op = '0;
			idle_op = '0;
			phase = S_IDLE;
			waits_left = '0;
			group_index = '0;
			gathered_bits = '0;
			held_adaptive = 1'b0;
			held_row = '0;
			held_mode = 1'b0;
			held_unit = '0;
			held_cell = '0;
			upcoming_results.delete();
			outstanding = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_WAIT_CYCLES: wait_setting = cfg_data[2:0];
					REG_READ_OPCODE: read_op = cfg_data;
					REG_IDLE_OPCODE: idle_op = cfg_data;
					default: ;
				endcase
			end
			if (result_valid && !result_stall) begin
				seen_result = {result_kind, command_bit, data_byte, status, row_bits,
					unit_zero_bit, last};
				compare_result(seen_result);
			end
			if (item_valid && !item_stall) begin
				seen_item = {kind, adaptive_wordline, row_address, single_unit, unit_select,
					cell_select, response_valid, response_data};
				step_read_sequence(seen_item);
			end
			outstanding = upcoming_results.size();
		end
	end

endmodule

@@ tb/tb_top.sv @@
// Top of the read command sequencer testbench: clock, reset, stimulus and verdict.
// Depends on rcs_pkg, the read_command_sequencer RTL and read_sequence_checker.
module tb_top;
	import rcs_pkg::*;

	// Generous bound on the whole run; the slowest legal run is far below it.
	localparam int CYCLE_LIMIT = 500000;
	// Cycles allowed after the last expected result before the block is
	// considered idle. The pipeline is two registers deep and an abort holds
	// the result register for one more result, the protocol error.
	localparam int DRAIN_CYCLES = 8;
	// Response positions for run_read: play the whole read, or pick a spot.
	localparam int TO_END = 1000;
	localparam int ANYWHERE = -1;
	// Items per random phase, counting only those that take part in a read.
	localparam int PHASE_ITEMS = 100;

	logic                   clk;
	logic                   arst_n;
	logic                   item_valid;
	logic                   item_stall;
	logic                   kind;
	logic                   adaptive_wordline;
	logic [6:0]             row_address;
	logic                   single_unit;
	logic [6:0]             unit_select;
	logic [1:0]             cell_select;
	logic                   response_valid;
	logic [7:0]             response_data;
	logic                   result_valid;
	logic                   result_stall;
	logic                   result_kind;
	logic                   command_bit;
	logic [7:0]             data_byte;
	logic [1:0]             status;
	logic [63:0]            row_bits;
	logic                   unit_zero_bit;
	logic                   last;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	int fail_count;
	int outstanding;
	int results_taken;
	int reads_done;
	int rejects;
	int aborts;

	// The stimulus needs the current wait count to build well-formed reads.
	logic [2:0] cfg_wait;
	// When set, the sender offers items back to back with no gaps.
	logic       calm;
	int         items_sent;
	int         settings_applied;
	int         cycle_count;

	read_command_sequencer u_top (.*);

	read_sequence_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// The watchdog counts cycles and ends the run if the stimulus or the
	// drain ever hangs, e.g. because a result never shows up.
	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Test completed with failures");
		$finish;
	end

	// Most gaps are empty or short; now and then a long one.
	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Receiver back-pressure runs on its own. Free-flowing stretches
	// alternate with stalls, and every so often a long free stretch lets
	// the block run at full rate.
	initial begin : result_backpressure
		int free_run;
		int hold;
		result_stall = 1'b0;
		forever begin
			free_run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 8);
			repeat (free_run) @(negedge clk) result_stall = 1'b0;
			hold = idle_gap();
			repeat (hold) @(negedge clk) result_stall = 1'b1;
		end
	end

	// Offers one item and returns at the falling edge after its transfer.
	// Valid is left high so that back-to-back items never drop it; callers
	// that pause lower it themselves. Entered at a falling edge.
	task automatic send_item(input item_t it);
		int gap;
		gap = calm ? 0 : idle_gap();
		if (gap > 0) begin
			item_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid = 1'b1;
		{kind, adaptive_wordline, row_address, single_unit, unit_select, cell_select,
			response_valid, response_data} = it;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	// Waits until every predicted result has been taken, then lets the
	// pipeline drain, since an ignored response leaves nothing to wait for.
	task automatic wait_until_quiet();
		item_valid = 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Registers are only rewritten with the block idle.
	task automatic apply_settings(input logic [2:0] waits, input logic [7:0] read_op,
			input logic [7:0] idle_op);
		wait_until_quiet();
		write_reg(REG_WAIT_CYCLES, {5'd0, waits});
		write_reg(REG_READ_OPCODE, read_op);
		write_reg(REG_IDLE_OPCODE, idle_op);
		cfg_wait = waits;
		settings_applied++;
	endtask

	// A start item with random fields. Single-mode starts get a legal unit;
	// callers that want an out-of-range unit set it themselves. In row mode
	// the unit field is ignored by the block, so any value goes.
	function automatic item_t random_start();
		item_t it;
		logic [31:0] r;
		r = $urandom;
		it = r[$bits(item_t)-1:0];
		it.kind = KIND_START;
		if (it.single_unit && it.unit_select > UNIT_MAX)
			it.unit_select = 7'($urandom_range(0, 64));
		return it;
	endfunction

	// A chip response; the start fields carry random junk, which the block
	// must ignore on a response.
	function automatic item_t reply(input logic valid_flag, input logic [7:0] data);
		item_t it;
		logic [31:0] r;
		r = $urandom;
		it = r[$bits(item_t)-1:0];
		it.kind = KIND_RESPONSE;
		it.response_valid = valid_flag;
		it.response_data = data;
		return it;
	endfunction

	// Turns a good response into one the block must reject. Stage 0 is a
	// progress code, stage 1 a row group (only the valid flag matters there),
	// stage 2 a result bit.
	function automatic item_t spoil_reply(input item_t it, input int stage);
		item_t r;
		r = it;
		case (stage)
			0: if ($urandom_range(0, 1) == 0) r.response_valid = 1'b1;
				else r.response_data = r.response_data ^ 8'($urandom_range(1, 255));
			1: r.response_valid = 1'b0;
			default: if ($urandom_range(0, 1) == 0) r.response_valid = 1'b0;
				else r.response_data = r.response_data | {7'($urandom_range(1, 127)), 1'b0};
		endcase
		return r;
	endfunction

	// Plays one read: the start item, then the chip responses a healthy chip
	// would give. The responses stop at stop_at (TO_END plays them all,
	// ANYWHERE picks a random spot). With spoil set, the response at that
	// spot is corrupted, which must make the block abort. Stopping without
	// spoiling leaves the block mid-read, so the next start interrupts it.
	task automatic run_read(input item_t req, input int stop_at, input logic spoil,
			output int sent);
		item_t replies[$];
		int stop;
		int stage;
		int i;
		replies = {};
		if (!(req.single_unit && req.unit_select > UNIT_MAX)) begin
			replies.push_back(reply(1'b0, PROG_CMD));
			replies.push_back(reply(1'b0, PROG_ADAPT));
			replies.push_back(reply(1'b0, PROG_ROW));
			replies.push_back(reply(1'b0, PROG_MODE));
			replies.push_back(reply(1'b0, PROG_UNIT));
			replies.push_back(reply(1'b0, PROG_CELL));
			replies.push_back(reply(1'b0, PROG_START));
			repeat (cfg_wait) replies.push_back(reply(1'b0, PROG_WAIT));
			if (!req.single_unit) begin
				repeat (8) replies.push_back(reply(1'b1, 8'($urandom)));
			end
			replies.push_back(reply(1'b1, {7'd0, 1'($urandom)}));
		end
		stop = stop_at;
		if (stop < 0) stop = (replies.size() > 0) ? $urandom_range(0, replies.size() - 1) : 0;
		if (stop > replies.size()) stop = replies.size();
		send_item(req);
		sent = 1;
		for (i = 0; i < stop; i++) begin
			send_item(replies[i]);
			sent++;
		end
		if (spoil && stop < replies.size()) begin
			if (stop < 7 + cfg_wait) stage = 0;
			else if (!req.single_unit && stop < 15 + cfg_wait) stage = 1;
			else stage = 2;
			send_item(spoil_reply(replies[stop], stage));
			sent++;
		end
	endtask

	// One random phase: mostly complete reads with random content, plus
	// aborted reads, interrupted reads, rejected units and stray responses.
	task automatic random_phase();
		item_t req;
		int phase_items;
		int pick;
		int n;
		phase_items = 0;
		while (phase_items < PHASE_ITEMS) begin
			calm = ($urandom_range(0, 4) == 0);
			pick = $urandom_range(0, 99);
			req = random_start();
			if (pick < 5) begin
				// Stray responses; ignored while idle, fatal mid-read.
				repeat ($urandom_range(1, 2)) send_item(reply(1'($urandom), 8'($urandom)));
			end else if (pick < 10) begin
				req.single_unit = 1'b1;
				req.unit_select = 7'($urandom_range(65, 127));
				run_read(req, TO_END, 1'b0, n);
				phase_items += n;
			end else if (pick < 22) begin
				run_read(req, ANYWHERE, 1'b1, n);
				phase_items += n;
			end else if (pick < 30) begin
				run_read(req, ANYWHERE, 1'b0, n);
				phase_items += n;
			end else begin
				run_read(req, TO_END, 1'b0, n);
				phase_items += n;
			end
		end
	endtask

	initial begin : stimulus
		item_t req;
		int n;
		arst_n = 1'b0;
		item_valid = 1'b0;
		{kind, adaptive_wordline, row_address, single_unit, unit_select, cell_select,
			response_valid, response_data} = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cfg_wait = 3'd0;
		calm = 1'b0;
		items_sent = 0;
		settings_applied = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part. A single wait response keeps the reads short but still
		// exercises the wait phase.
		apply_settings(3'd1, 8'h3C, 8'hC3);
		// A response with no read under way must produce nothing.
		send_item(reply(1'b1, 8'hFF));
		// Single-mode units just past the array and at the top of the field
		// are rejected at once with no transfer.
		req = random_start();
		req.single_unit = 1'b1;
		req.unit_select = 7'd65;
		run_read(req, TO_END, 1'b0, n);
		req.unit_select = 7'h7F;
		run_read(req, TO_END, 1'b0, n);
		// A complete single read at the highest unit with all fields at their top.
		req = random_start();
		req.single_unit = 1'b1;
		req.unit_select = UNIT_MAX;
		req.row_address = 7'h7F;
		req.cell_select = 2'd3;
		req.adaptive_wordline = 1'b1;
		run_read(req, TO_END, 1'b0, n);
		// A row read with an oversized unit field, which must go out as zero,
		// cut off after two responses ...
		req = random_start();
		req.single_unit = 1'b0;
		req.unit_select = 7'h7F;
		req.row_address = 7'd0;
		req.cell_select = 2'd0;
		req.adaptive_wordline = 1'b0;
		run_read(req, 2, 1'b0, n);
		// ... by a new start for unit zero whose command response is wrong.
		req = random_start();
		req.single_unit = 1'b1;
		req.unit_select = 7'd0;
		run_read(req, 0, 1'b1, n);
		// After the abort the block is idle again and ignores this one.
		send_item(reply(1'b0, PROG_CMD));

		// Random part over several register settings, extremes first.
		apply_settings(3'd0, 8'h00, 8'hFF);
		random_phase();
		apply_settings(3'd7, 8'hFF, 8'h00);
		random_phase();
		apply_settings(3'($urandom), 8'($urandom), 8'($urandom));
		random_phase();
		apply_settings(3'($urandom), 8'($urandom), 8'($urandom));
		random_phase();

		wait_until_quiet();
		$display("Sent %0d items under %0d register settings; checked %0d result transfers.",
			items_sent, settings_applied, results_taken);
		$display("Reads: %0d finished, %0d rejected for a bad unit, %0d aborted by the chip.",
			reads_done, rejects, aborts);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
